// ----- hdl/frame_bitmap_allocator_top_macros.svh -----
// Assertion macros shared by the checkers of the frame bitmap allocator.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fba port check failed");

// The consequent must hold in the cycle after the antecedent.
`define FBA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fba port check failed");

`endif

// ----- hdl/fba_pkg.sv -----
package fba_pkg;

   // Width of a frame number on the request and response ports.
   localparam int FI_W = 15;
   // Width of the frame count register and its value after reset.
   localparam int CSR_W = 16;
   localparam logic [CSR_W-1:0] CSR_RESET = 16'h8000;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_FREE    = 2'd1,
      REQ_TEST    = 2'd2,
      REQ_RESERVE = 2'd3
   } fba_req_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NO_CHANGE = 2'd1,
      STATUS_NO_FRAMES = 2'd2,
      STATUS_RANGE     = 2'd3
   } fba_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_FREAD,
      ST_FMOD,
      ST_SCAN
   } fba_state_type;

endpackage

// ----- hdl/frame_bitmap_allocator_top.sv -----
// Frame bitmap allocator. A request beat is taken when start is high and busy is low; its
// single response appears on the rsp_ ports for exactly one cycle, marked by rsp_strobe,
// and cannot be stalled, so the receiver must capture it in that cycle. Requests that need
// no bitmap access (allocate on a present entry, free on an absent entry, and free, test or
// reserve of a frame at or above the limit) answer in the cycle after the beat and leave
// busy low. Free, test and reserve of a valid frame split the frame number into word and
// bit (a multiply by the reciprocal of WORD_BITS when the beat is taken, then a subtract
// for the bit index), then read and update the bitmap word in states ST_DIV, ST_FREAD and
// ST_FMOD; the response is loaded in ST_FMOD and its strobe is registered. Allocate scans
// the bitmap memory one word per cycle from word 0 through its single read port; the
// response is loaded when the scan reaches a word with a zero bit, or when every word
// is full. After reset the block clears the bitmap memory one word per cycle and holds
// busy high until the last word is cleared; the frame count register can be written
// during that time.
module frame_bitmap_allocator_top
   import fba_pkg::*;
#(
   parameter int unsigned MAX_FRAMES   = 32768,
   parameter int unsigned BITMAP_WORDS = 1024,
   parameter int unsigned WORD_BITS    = 32
) (
   input  logic            clock,
   input  logic            reset,

   input  logic            start,
   output logic            busy,
   input  logic [1:0]      req_type,
   input  logic [FI_W-1:0] req_frame_index,
   input  logic            req_entry_present,
   input  logic            req_is_kernel,
   input  logic            req_is_writeable,

   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata,

   output logic            rsp_strobe,
   output logic [1:0]      rsp_status,
   output logic [FI_W-1:0] rsp_result_frame,
   output logic            rsp_out_present,
   output logic            rsp_out_writable,
   output logic            rsp_out_user,
   output logic            rsp_occupied
);

   // Address widths of the bitmap memory; the scan counter has one bit more so that it can
   // reach BITMAP_WORDS and stop.
   localparam int WIDX_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int SCAN_W = WIDX_W + 1;
   localparam int BIDX_W = $clog2(WORD_BITS);

   // The word index is the frame number times a rounded-up reciprocal of WORD_BITS, shifted
   // down. With the shift at FI_W plus the bit index width the quotient is exact for every
   // frame number.
   localparam int RECIP_SH = FI_W + BIDX_W;
   localparam int RECIP_W  = FI_W + 2;
   localparam int PROD_W   = FI_W + RECIP_W;
   localparam longint unsigned RECIP =
      ((longint'(1) << RECIP_SH) + longint'(WORD_BITS) - longint'(1)) / longint'(WORD_BITS);

   // The frame limit is the smallest of the register, MAX_FRAMES and the bitmap size.
   localparam longint unsigned TOTAL_BITS = longint'(BITMAP_WORDS) * longint'(WORD_BITS);
   localparam longint unsigned CAP =
      (longint'(MAX_FRAMES) < TOTAL_BITS) ? longint'(MAX_FRAMES) : TOTAL_BITS;
   localparam int TB_W = $clog2(TOTAL_BITS + 1);
   localparam int CMP_W = (TB_W > CSR_W) ? TB_W : CSR_W;

   // Sequencer.
   fba_state_type state_ff, state_in;

   // Configuration.
   logic [CSR_W-1:0] frame_count_ff;

   // Captured request.
   fba_req_type     op_ff;
   logic [FI_W-1:0] fi_ff;
   logic            kern_ff;
   logic            wr_ff;

   // Word and bit index of the frame: div_ff is loaded with the word index when the beat is
   // taken, and rem_ff gets the bit index in the following cycle.
   logic [FI_W-1:0]   div_ff;
   logic [BIDX_W-1:0] rem_ff;

   // Scan pipeline: scan_ff is the next word to read, chk_ff marks read data in flight for
   // word chk_addr_ff, and base_ff is the first frame of that word.
   logic [SCAN_W-1:0] scan_ff;
   logic              chk_ff;
   logic [WIDX_W-1:0] chk_addr_ff;
   logic [CMP_W-1:0]  base_ff;

   // Clearing pass after reset.
   logic [WIDX_W-1:0] clr_ff;

   // Bitmap memory with a registered read port.
   logic [WORD_BITS-1:0] bitmap_ff [BITMAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   // Response register.
   logic            rsp_strobe_ff;
   fba_status_type  rsp_status_ff;
   logic [FI_W-1:0] rsp_frame_ff;
   logic            rsp_present_ff;
   logic            rsp_writable_ff;
   logic            rsp_user_ff;
   logic            rsp_occupied_ff;

   // Decoded request and derived values.
   fba_req_type          req_op;
   logic [CMP_W-1:0]     lim;
   logic                 accept;
   logic                 fi_out_of_range;
   logic                 rsp_now;

   logic [PROD_W-1:0]    div_prod;
   logic [FI_W-1:0]      div_quot;
   logic [FI_W-1:0]      div_rem;
   logic [WORD_BITS-1:0] bit_mask;

   logic                 word_full;
   logic [WORD_BITS-1:0] lz_onehot;
   logic [BIDX_W-1:0]    lz_idx;
   logic [CMP_W-1:0]     cand;
   logic                 cand_ok;
   logic                 scan_more;
   logic                 clr_last;

   // Sequencer outputs.
   logic                 div_load;
   logic                 scan_load;
   logic                 mem_re;
   logic [WIDX_W-1:0]    mem_raddr;
   logic                 mem_we;
   logic [WIDX_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 rsp_load;
   fba_status_type       rsp_status_in;
   logic [FI_W-1:0]      rsp_frame_in;
   logic                 rsp_present_in;
   logic                 rsp_writable_in;
   logic                 rsp_user_in;
   logic                 rsp_occupied_in;

   assign req_op = fba_req_type'(req_type);
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   assign lim = (CMP_W'(frame_count_ff) < CMP_W'(CAP)) ? CMP_W'(frame_count_ff)
                                                      : CMP_W'(CAP);
   assign fi_out_of_range = (CMP_W'(req_frame_index) >= lim);

   // A request answers at once when it touches no bitmap word.
   assign rsp_now = ((req_op == REQ_ALLOC) && req_entry_present) ||
                    ((req_op == REQ_FREE) && !req_entry_present) ||
                    ((req_op != REQ_ALLOC) && fi_out_of_range);

   // Word index from the incoming frame number; the bit index is what is left over.
   assign div_prod = PROD_W'(req_frame_index) * PROD_W'(RECIP);
   assign div_quot = FI_W'(div_prod >> RECIP_SH);
   assign div_rem  = fi_ff - (div_ff * FI_W'(WORD_BITS));
   assign bit_mask = WORD_BITS'(1) << rem_ff;

   // Lowest zero bit of the word under test, as one-hot and as an index. A full word
   // gives no bit at all.
   assign word_full = &rd_data_ff;
   assign lz_onehot = ~rd_data_ff & (rd_data_ff + WORD_BITS'(1));

   always_comb begin
      lz_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lz_onehot[i]) begin
            lz_idx = lz_idx | BIDX_W'(i);
         end
      end
   end

   // Frames above the lowest zero bit are all larger, so if the lowest one is past the
   // limit there is no free frame anywhere further on.
   assign cand      = base_ff + CMP_W'(lz_idx);
   assign cand_ok   = (cand < lim);
   assign scan_more = (scan_ff < SCAN_W'(BITMAP_WORDS));
   assign clr_last  = (clr_ff == WIDX_W'(BITMAP_WORDS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && !rsp_now) begin
               state_in = (req_op == REQ_ALLOC) ? ST_SCAN : ST_DIV;
            end
         end
         ST_DIV: begin
            state_in = ST_FREAD;
         end
         ST_FREAD: begin
            state_in = ST_FMOD;
         end
         ST_FMOD: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if ((chk_ff && !word_full) || (!chk_ff && !scan_more)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Sequencer outputs: memory port controls and the response to load.
   always_comb begin
      div_load        = 1'b0;
      scan_load       = 1'b0;
      mem_re          = 1'b0;
      mem_raddr       = '0;
      mem_we          = 1'b0;
      mem_waddr       = '0;
      mem_wdata       = '0;
      rsp_load        = 1'b0;
      rsp_status_in   = STATUS_DONE;
      rsp_frame_in    = fi_ff;
      rsp_present_in  = 1'b0;
      rsp_writable_in = 1'b0;
      rsp_user_in     = 1'b0;
      rsp_occupied_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         ST_IDLE: begin
            if (start) begin
               if (rsp_now) begin
                  rsp_load     = 1'b1;
                  rsp_frame_in = req_frame_index;
                  priority if ((req_op == REQ_ALLOC) && req_entry_present) begin
                     rsp_status_in  = STATUS_NO_CHANGE;
                     rsp_present_in = 1'b1;
                  end else if ((req_op == REQ_FREE) && !req_entry_present) begin
                     rsp_status_in = STATUS_NO_CHANGE;
                  end else begin
                     // Frames past the limit count as busy.
                     rsp_status_in   = STATUS_RANGE;
                     rsp_occupied_in = (req_op == REQ_TEST);
                  end
               end else if (req_op == REQ_ALLOC) begin
                  scan_load = 1'b1;
               end else begin
                  div_load = 1'b1;
               end
            end
         end
         ST_DIV: begin
         end
         ST_FREAD: begin
            mem_re    = 1'b1;
            mem_raddr = div_ff[WIDX_W-1:0];
         end
         ST_FMOD: begin
            rsp_load  = 1'b1;
            mem_waddr = div_ff[WIDX_W-1:0];
            unique case (op_ff)
               REQ_FREE: begin
                  mem_we          = 1'b1;
                  mem_wdata       = rd_data_ff & ~bit_mask;
                  rsp_frame_in    = '0;
                  rsp_writable_in = 1'b1;
               end
               REQ_TEST: begin
                  rsp_occupied_in = |(rd_data_ff & bit_mask);
               end
               REQ_RESERVE: begin
                  mem_we    = 1'b1;
                  mem_wdata = rd_data_ff | bit_mask;
               end
               REQ_ALLOC: begin
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            mem_re    = scan_more;
            mem_raddr = scan_ff[WIDX_W-1:0];
            if (chk_ff && !word_full) begin
               rsp_load = 1'b1;
               if (cand_ok) begin
                  mem_we          = 1'b1;
                  mem_waddr       = chk_addr_ff;
                  mem_wdata       = rd_data_ff | lz_onehot;
                  rsp_frame_in    = FI_W'(cand);
                  rsp_present_in  = 1'b1;
                  rsp_writable_in = wr_ff;
                  rsp_user_in     = !kern_ff;
               end else begin
                  rsp_status_in = STATUS_NO_FRAMES;
                  rsp_frame_in  = '0;
               end
            end else if (!chk_ff && !scan_more) begin
               rsp_load      = 1'b1;
               rsp_status_in = STATUS_NO_FRAMES;
               rsp_frame_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         frame_count_ff <= CSR_RESET;
         clr_ff         <= '0;
         chk_ff         <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_load;
         if (csr_we) begin
            frame_count_ff <= csr_wdata;
         end
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + WIDX_W'(1);
         end
         if (scan_load) begin
            chk_ff <= 1'b0;
         end else if (state_ff == ST_SCAN) begin
            chk_ff <= scan_more;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         fi_ff   <= req_frame_index;
         kern_ff <= req_is_kernel;
         wr_ff   <= req_is_writeable;
      end

      if (div_load) begin
         div_ff <= div_quot;
      end
      if (state_ff == ST_DIV) begin
         rem_ff <= div_rem[BIDX_W-1:0];
      end

      if (scan_load) begin
         scan_ff <= '0;
         base_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         if (scan_more) begin
            scan_ff     <= scan_ff + SCAN_W'(1);
            chk_addr_ff <= scan_ff[WIDX_W-1:0];
         end
         if (chk_ff && word_full) begin
            base_ff <= base_ff + CMP_W'(WORD_BITS);
         end
      end

      if (rsp_load) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_frame_ff    <= rsp_frame_in;
         rsp_present_ff  <= rsp_present_in;
         rsp_writable_ff <= rsp_writable_in;
         rsp_user_ff     <= rsp_user_in;
         rsp_occupied_ff <= rsp_occupied_in;
      end
   end

   // Bitmap memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= bitmap_ff[mem_raddr];
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_frame = rsp_frame_ff;
   assign rsp_out_present  = rsp_present_ff;
   assign rsp_out_writable = rsp_writable_ff;
   assign rsp_out_user     = rsp_user_ff;
   assign rsp_occupied     = rsp_occupied_ff;

endmodule

// ----- hdl/fba_checker.sv -----
`include "frame_bitmap_allocator_top_macros.svh"

module fba_checker
   import fba_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_strobe,
   input logic [1:0]      rsp_status,
   input logic [FI_W-1:0] rsp_result_frame,
   input logic            rsp_out_present,
   input logic            rsp_out_writable,
   input logic            rsp_out_user,
   input logic            rsp_occupied
);

   // A taken beat either answers in the next cycle or keeps the block busy.
   `FBA_ASSERT_NEXT(a_beat_answers_or_busy, start && !busy, rsp_strobe || busy)

   // The response goes out as the block becomes free again.
   `FBA_ASSERT_NOW(a_strobe_when_free, rsp_strobe, !busy)

   // Out of frames carries no frame and no flags.
   `FBA_ASSERT_NOW(a_no_frames_clean, rsp_strobe && (rsp_status == STATUS_NO_FRAMES),
      (rsp_result_frame == '0) && !rsp_out_present && !rsp_out_writable && !rsp_out_user)

   // Only a test reports an occupied frame, and a test never sets entry flags.
   `FBA_ASSERT_NOW(a_occupied_is_test, rsp_strobe && rsp_occupied,
      ((rsp_status == STATUS_DONE) || (rsp_status == STATUS_RANGE)) &&
      !rsp_out_present && !rsp_out_writable && !rsp_out_user)

endmodule

bind frame_bitmap_allocator_top fba_checker u_fba_checker (.*);
